@@ hdl/qtw_pkg.sv @@
// Shared constants, codes and item types of the quenched trap walk step block.
package qtw_pkg;

    localparam int LIST_DEPTH_DEF    = 1024;
    localparam int FRACTION_BITS_DEF = 8;
    localparam int QUEUE_DEPTH       = 2;

    localparam int OPERATION_W   = 2;
    localparam int TABLE_INDEX_W = 10;
    localparam int WAIT_W        = 48;
    localparam int RANDOM_W      = 16;
    localparam int POS_X_W       = 32;
    localparam int POS_Y_W       = 11;
    localparam int TIME_W        = 64;
    localparam int LIST_SIZE_W   = 11;
    localparam int TIME_LIMIT_W  = 32;
    localparam int CFG_INDEX_W   = 2;
    localparam int CFG_DATA_W    = 32;

    localparam int LIST_SIZE_RESET  = 250;
    localparam int Y_LOWER_RESET    = -5;
    localparam int Y_UPPER_RESET    = 5;
    localparam int TIME_LIMIT_RESET = 500;

    localparam logic signed [POS_X_W-1:0] X_MAX = {1'b0, {(POS_X_W-1){1'b1}}};
    localparam logic signed [POS_X_W-1:0] X_MIN = {1'b1, {(POS_X_W-1){1'b0}}};

    typedef enum logic [OPERATION_W-1:0] {
        OP_LOAD_X,
        OP_LOAD_Y,
        OP_RESTART,
        OP_STEP
    } op_t;

    typedef enum logic [1:0] {
        DIR_RIGHT,
        DIR_LEFT,
        DIR_UP,
        DIR_DOWN
    } dir_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_LIST_SIZE,
        REG_Y_LOWER,
        REG_Y_UPPER,
        REG_TIME_LIMIT
    } cfg_reg_t;

    typedef struct packed {
        op_t                      kind;
        dir_t                     dir;
        logic                     write_x;
        logic                     write_y;
        logic [TABLE_INDEX_W-1:0] index;
        logic [WAIT_W-1:0]        wait_value;
    } cmd_t;

    typedef struct packed {
        logic signed [POS_X_W-1:0] pos_x;
        logic signed [POS_Y_W-1:0] pos_y;
        logic [TIME_W-1:0]         elapsed_time;
        logic                      stepped;
        logic                      finished;
    } res_t;

endpackage

@@ hdl/qtw_queue.sv @@
// Small first-in first-out queue used between the pipeline parts.
module qtw_queue
    import qtw_pkg::*;
#(
    parameter int WIDTH = 1,
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] in_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] out_data,
    output logic             empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slots_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             wr_en;
    logic             rd_en;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign wr_en    = push && !full;
    assign rd_en    = pop && !empty;
    assign out_data = slots_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr_en)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (rd_en)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (wr_en && !rd_en)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (rd_en && !wr_en)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            slots_reg[wr_ptr_reg] <= in_data;
        end
    end

endmodule

@@ hdl/qtw_front.sv @@
// Front part: accepts input items and decodes them into commands.
module qtw_front
    import qtw_pkg::*;
#(
    parameter int LIST_DEPTH = LIST_DEPTH_DEF
)
(
    input  logic                     push,
    input  logic                     q_full,
    input  logic [OPERATION_W-1:0]   operation,
    input  logic [TABLE_INDEX_W-1:0] table_index,
    input  logic [WAIT_W-1:0]        wait_value,
    input  logic [RANDOM_W-1:0]      random_word,
    output logic                     full,
    output logic                     q_push,
    output cmd_t                     cmd
);

    localparam int DEPTH_W = $clog2(LIST_DEPTH + 1);
    localparam int CMP_W   = (DEPTH_W > TABLE_INDEX_W) ? DEPTH_W : TABLE_INDEX_W + 1;

    logic index_ok;

    assign full     = q_full;
    assign q_push   = push && !q_full;
    assign index_ok = CMP_W'(table_index) < CMP_W'(LIST_DEPTH);

    always_comb
    begin
        cmd.kind       = op_t'(operation);
        cmd.index      = table_index;
        cmd.wait_value = wait_value;
        cmd.write_x    = (op_t'(operation) == OP_LOAD_X) && index_ok;
        cmd.write_y    = (op_t'(operation) == OP_LOAD_Y) && index_ok;
        case (random_word[RANDOM_W-1 -: 3]) inside
            [3'd0:3'd2]: cmd.dir = DIR_RIGHT;
            3'd3:        cmd.dir = DIR_LEFT;
            [3'd4:3'd5]: cmd.dir = DIR_UP;
            default:     cmd.dir = DIR_DOWN;
        endcase
    end

endmodule

@@ hdl/qtw_back.sv @@
// Back part: configuration registers, walker state, wait tables and time accumulation.
module qtw_back
    import qtw_pkg::*;
#(
    parameter int LIST_DEPTH    = LIST_DEPTH_DEF,
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   cmd_valid,
    input  cmd_t                   cmd,
    output logic                   cmd_ready,
    input  logic                   res_ready,
    output logic                   res_valid,
    output res_t                   res
);

    localparam int SLOT_W     = $clog2(LIST_DEPTH);
    localparam int CNT_W      = SLOT_W + 1;
    localparam int CMP_W      = (CNT_W > LIST_SIZE_W) ? CNT_W : LIST_SIZE_W;
    localparam int LIM_W      = TIME_LIMIT_W + FRACTION_BITS;
    localparam int RESET_USED = (LIST_SIZE_RESET > LIST_DEPTH) ? LIST_DEPTH : LIST_SIZE_RESET;
    localparam int RESET_HALF = RESET_USED / 2;

    function automatic logic [SLOT_W-1:0] clamp_slot(input logic [CNT_W-1:0] v,
                                                     input logic [SLOT_W-1:0] last);
        return (v > {1'b0, last}) ? last : v[SLOT_W-1:0];
    endfunction

    logic [LIST_SIZE_W-1:0]    list_size_reg;
    logic signed [POS_Y_W-1:0] y_lower_reg;
    logic signed [POS_Y_W-1:0] y_upper_reg;
    logic [TIME_LIMIT_W-1:0]   time_limit_reg;

    logic signed [POS_X_W-1:0] walker_x_reg;
    logic signed [POS_X_W-1:0] walker_x_next;
    logic signed [POS_Y_W-1:0] walker_y_reg;
    logic signed [POS_Y_W-1:0] walker_y_next;
    logic [SLOT_W-1:0]         x_slot_reg;
    logic [SLOT_W-1:0]         x_slot_next;
    logic [SLOT_W-1:0]         y_slot_reg;
    logic [SLOT_W-1:0]         y_slot_next;
    logic [TIME_W-1:0]         clock_time_reg;
    logic [TIME_W-1:0]         clock_time_next;

    logic                      b_valid_reg;
    logic                      b_valid_next;
    logic                      b_step_reg;
    logic                      b_zero_reg;
    logic [WAIT_W-1:0]         x_rd_reg;
    logic [WAIT_W-1:0]         y_rd_reg;

    logic [WAIT_W-1:0]         table_x_mem [LIST_DEPTH];
    logic [WAIT_W-1:0]         table_y_mem [LIST_DEPTH];

    logic [CMP_W-1:0]          size_wide;
    logic [CNT_W-1:0]          used;
    logic [CNT_W-1:0]          used_m1;
    logic [CNT_W-1:0]          used_half;
    logic [SLOT_W-1:0]         last_slot;
    logic [SLOT_W-1:0]         half_slot;
    logic [TIME_W-1:0]         limit_wide;
    logic                      go;
    logic                      a_fire;
    logic                      b_adv;

    logic signed [POS_X_W-1:0] x_step;
    logic signed [POS_Y_W:0]   y_ext;
    logic signed [POS_Y_W:0]   y_move;
    logic signed [POS_Y_W:0]   lower_ext;
    logic signed [POS_Y_W:0]   upper_ext;
    logic signed [POS_Y_W-1:0] y_step;
    logic [CNT_W-1:0]          x_cand;
    logic [CNT_W-1:0]          y_cand;
    logic                      x_moves;
    logic                      y_moves;
    logic [SLOT_W-1:0]         x_slot_step;
    logic [SLOT_W-1:0]         y_slot_step;
    logic [SLOT_W-1:0]         rd_addr_x;
    logic [SLOT_W-1:0]         rd_addr_y;
    logic [CMP_W-1:0]          index_wide;
    logic [SLOT_W-1:0]         wr_addr;

    logic [WAIT_W-1:0]         wait_max;
    logic [TIME_W:0]           time_sum;
    logic [TIME_W-1:0]         time_out;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            list_size_reg  <= LIST_SIZE_W'(LIST_SIZE_RESET);
            y_lower_reg    <= POS_Y_W'(Y_LOWER_RESET);
            y_upper_reg    <= POS_Y_W'(Y_UPPER_RESET);
            time_limit_reg <= TIME_LIMIT_W'(TIME_LIMIT_RESET);
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_LIST_SIZE:  list_size_reg  <= cfg_data[LIST_SIZE_W-1:0];
                REG_Y_LOWER:    y_lower_reg    <= cfg_data[POS_Y_W-1:0];
                REG_Y_UPPER:    y_upper_reg    <= cfg_data[POS_Y_W-1:0];
                REG_TIME_LIMIT: time_limit_reg <= cfg_data[TIME_LIMIT_W-1:0];
                default:        ;
            endcase
        end
    end

    assign size_wide = CMP_W'(list_size_reg);

    always_comb
    begin
        if (list_size_reg == '0)
        begin
            used = CNT_W'(1);
        end
        else if (size_wide > CMP_W'(LIST_DEPTH))
        begin
            used = CNT_W'(LIST_DEPTH);
        end
        else
        begin
            used = size_wide[CNT_W-1:0];
        end
    end

    assign used_m1    = used - CNT_W'(1);
    assign used_half  = used >> 1;
    assign last_slot  = used_m1[SLOT_W-1:0];
    assign half_slot  = used_half[SLOT_W-1:0];
    assign limit_wide = TIME_W'(LIM_W'(time_limit_reg) << FRACTION_BITS);
    assign go         = clock_time_reg < limit_wide;

    // Hold a new item while a step still accumulates its time.
    assign b_adv     = b_valid_reg && res_ready;
    assign cmd_ready = !b_valid_reg || (res_ready && !b_step_reg);
    assign a_fire    = cmd_valid && cmd_ready;

    assign y_ext     = {walker_y_reg[POS_Y_W-1], walker_y_reg};
    assign lower_ext = {y_lower_reg[POS_Y_W-1], y_lower_reg};
    assign upper_ext = {y_upper_reg[POS_Y_W-1], y_upper_reg};

    always_comb
    begin
        x_step  = walker_x_reg;
        y_move  = y_ext;
        x_cand  = {1'b0, x_slot_reg};
        y_cand  = {1'b0, y_slot_reg};
        x_moves = 1'b0;
        y_moves = 1'b0;
        case (cmd.dir)
            DIR_RIGHT:
            begin
                if (walker_x_reg != X_MAX)
                begin
                    x_step = walker_x_reg + POS_X_W'(1);
                end
                x_cand  = {1'b0, x_slot_reg} + CNT_W'(1);
                x_moves = 1'b1;
            end
            DIR_LEFT:
            begin
                if (walker_x_reg != X_MIN)
                begin
                    x_step = walker_x_reg - POS_X_W'(1);
                end
                if (x_slot_reg != '0)
                begin
                    x_cand = {1'b0, x_slot_reg} - CNT_W'(1);
                end
                x_moves = 1'b1;
            end
            DIR_UP:
            begin
                y_move  = y_ext + (POS_Y_W + 1)'(1);
                y_cand  = {1'b0, y_slot_reg} + CNT_W'(1);
                y_moves = 1'b1;
            end
            default:
            begin
                y_move = y_ext - (POS_Y_W + 1)'(1);
                if (y_slot_reg != '0)
                begin
                    y_cand = {1'b0, y_slot_reg} - CNT_W'(1);
                end
                y_moves = 1'b1;
            end
        endcase
    end

    always_comb
    begin
        if (y_move > upper_ext)
        begin
            y_step = y_lower_reg;
        end
        else if (y_move < lower_ext)
        begin
            y_step = y_upper_reg;
        end
        else
        begin
            y_step = y_move[POS_Y_W-1:0];
        end
    end

    assign x_slot_step = x_moves ? clamp_slot(x_cand, last_slot) : x_slot_reg;
    assign y_slot_step = y_moves ? clamp_slot(y_cand, last_slot) : y_slot_reg;
    assign rd_addr_x   = clamp_slot({1'b0, x_slot_step}, last_slot);
    assign rd_addr_y   = clamp_slot({1'b0, y_slot_step}, last_slot);
    assign index_wide  = CMP_W'(cmd.index);
    assign wr_addr     = index_wide[SLOT_W-1:0];

    always_comb
    begin
        walker_x_next = walker_x_reg;
        walker_y_next = walker_y_reg;
        x_slot_next   = x_slot_reg;
        y_slot_next   = y_slot_reg;
        if (a_fire)
        begin
            unique case (cmd.kind)
                OP_RESTART:
                begin
                    walker_x_next = '0;
                    walker_y_next = '0;
                    x_slot_next   = half_slot;
                    y_slot_next   = half_slot;
                end
                OP_STEP:
                begin
                    if (go)
                    begin
                        walker_x_next = x_step;
                        walker_y_next = y_step;
                        x_slot_next   = x_slot_step;
                        y_slot_next   = y_slot_step;
                    end
                end
                default: ;
            endcase
        end
    end

    assign wait_max = b_zero_reg ? '0 : ((x_rd_reg > y_rd_reg) ? x_rd_reg : y_rd_reg);
    assign time_sum = {1'b0, clock_time_reg} + (TIME_W + 1)'(wait_max);

    always_comb
    begin
        if (!b_step_reg)
        begin
            time_out = clock_time_reg;
        end
        else if (time_sum[TIME_W])
        begin
            time_out = '1;
        end
        else
        begin
            time_out = time_sum[TIME_W-1:0];
        end
    end

    always_comb
    begin
        clock_time_next = clock_time_reg;
        if (b_adv && b_step_reg)
        begin
            clock_time_next = time_out;
        end
        else if (a_fire && (cmd.kind == OP_RESTART))
        begin
            clock_time_next = '0;
        end
    end

    always_comb
    begin
        b_valid_next = b_valid_reg;
        if (a_fire)
        begin
            b_valid_next = 1'b1;
        end
        else if (b_adv)
        begin
            b_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            walker_x_reg   <= '0;
            walker_y_reg   <= '0;
            x_slot_reg     <= SLOT_W'(RESET_HALF);
            y_slot_reg     <= SLOT_W'(RESET_HALF);
            clock_time_reg <= '0;
            b_valid_reg    <= 1'b0;
            b_step_reg     <= 1'b0;
            b_zero_reg     <= 1'b0;
        end
        else
        begin
            walker_x_reg   <= walker_x_next;
            walker_y_reg   <= walker_y_next;
            x_slot_reg     <= x_slot_next;
            y_slot_reg     <= y_slot_next;
            clock_time_reg <= clock_time_next;
            b_valid_reg    <= b_valid_next;
            if (a_fire)
            begin
                b_step_reg <= (cmd.kind == OP_STEP) && go;
                b_zero_reg <= (x_step == '0) && (y_step == '0);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_fire && cmd.write_x)
        begin
            table_x_mem[wr_addr] <= cmd.wait_value;
        end
        if (a_fire)
        begin
            x_rd_reg <= table_x_mem[rd_addr_x];
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_fire && cmd.write_y)
        begin
            table_y_mem[wr_addr] <= cmd.wait_value;
        end
        if (a_fire)
        begin
            y_rd_reg <= table_y_mem[rd_addr_y];
        end
    end

    assign res_valid        = b_valid_reg;
    assign res.pos_x        = walker_x_reg;
    assign res.pos_y        = walker_y_reg;
    assign res.elapsed_time = time_out;
    assign res.stepped      = b_step_reg;
    assign res.finished     = time_out >= limit_wide;

endmodule

@@ hdl/quenched_trap_walk_step.sv @@
// Top level of the quenched trap walk step block.
//
// Input items enter through a queue port: an item transfers on a rising edge with push high
// and full low. Operation 0 or 1 writes wait_value into the x or y waiting-time table at
// table_index, 2 restarts the walker at the origin, 3 takes one random step while the time is below the limit.
// Every item returns exactly one result on the output queue port: the oldest result stands
// on pos_x, pos_y, elapsed_time, stepped and finished while empty is low, and it transfers
// on a rising edge with pop high and empty low.
// Registers list_size, y_lower, y_upper and time_limit (indexes 0 to 3) are written through
// cfg_valid/cfg_ready, cfg_index and cfg_data; cfg_ready is always high. Write them only
// while no item is in flight.
// A result passes through the command queue, the back stage register and the result queue
// before it shows on the ports. A load or restart is taken as soon as the previous result
// moves on; a step holds the next item until its wait-table read has finished and its time
// add has settled, since the next item must judge the time limit.
// A two-entry queue sits on each side, so input keeps flowing while the receiver stalls,
// until both queues fill and full rises.
// Reset puts the walker at the origin, the time at zero, the registers at their defaults and
// both slots at half the list size. The wait tables are not cleared: load them before use.
module quenched_trap_walk_step
    import qtw_pkg::*;
#(
    parameter int LIST_DEPTH    = LIST_DEPTH_DEF,
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      push,
    output logic                      full,
    input  logic [OPERATION_W-1:0]    operation,
    input  logic [TABLE_INDEX_W-1:0]  table_index,
    input  logic [WAIT_W-1:0]         wait_value,
    input  logic [RANDOM_W-1:0]       random_word,
    output logic                      empty,
    input  logic                      pop,
    output logic signed [POS_X_W-1:0] pos_x,
    output logic signed [POS_Y_W-1:0] pos_y,
    output logic [TIME_W-1:0]         elapsed_time,
    output logic                      stepped,
    output logic                      finished,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [CFG_INDEX_W-1:0]    cfg_index,
    input  logic [CFG_DATA_W-1:0]     cfg_data
);

    cmd_t cmd_in;
    cmd_t cmd_q;
    logic cmd_push;
    logic cmd_full;
    logic cmd_empty;
    logic cmd_ready;
    res_t res_in;
    res_t res_q;
    logic res_valid;
    logic res_full;

    qtw_front #(
        .LIST_DEPTH (LIST_DEPTH)
    ) u_front (
        .push        (push),
        .q_full      (cmd_full),
        .operation   (operation),
        .table_index (table_index),
        .wait_value  (wait_value),
        .random_word (random_word),
        .full        (full),
        .q_push      (cmd_push),
        .cmd         (cmd_in)
    );

    qtw_queue #(
        .WIDTH ($bits(cmd_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_cmd_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (cmd_push),
        .in_data  (cmd_in),
        .full     (cmd_full),
        .pop      (cmd_ready),
        .out_data (cmd_q),
        .empty    (cmd_empty)
    );

    qtw_back #(
        .LIST_DEPTH    (LIST_DEPTH),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd_valid (!cmd_empty),
        .cmd       (cmd_q),
        .cmd_ready (cmd_ready),
        .res_ready (!res_full),
        .res_valid (res_valid),
        .res       (res_in)
    );

    qtw_queue #(
        .WIDTH ($bits(res_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_res_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (res_valid),
        .in_data  (res_in),
        .full     (res_full),
        .pop      (pop),
        .out_data (res_q),
        .empty    (empty)
    );

    assign pos_x        = res_q.pos_x;
    assign pos_y        = res_q.pos_y;
    assign elapsed_time = res_q.elapsed_time;
    assign stepped      = res_q.stepped;
    assign finished     = res_q.finished;

endmodule

@@ hdl/qtw_checker.sv @@
// Port-level checker of the quenched trap walk step block and its bind.
module qtw_checker
    import qtw_pkg::*;
(
    input logic                      clk,
    input logic                      rst_n,
    input logic                      push,
    input logic                      full,
    input logic                      pop,
    input logic                      empty,
    input logic signed [POS_X_W-1:0] pos_x,
    input logic signed [POS_Y_W-1:0] pos_y,
    input logic [TIME_W-1:0]         elapsed_time,
    input logic                      stepped,
    input logic                      finished
);

    localparam int CAP    = 2 * QUEUE_DEPTH + 1;
    localparam int HELD_W = $clog2(CAP + 2);

    logic [HELD_W-1:0] held_reg;
    logic [HELD_W-1:0] held_next;
    logic              in_xfer;
    logic              out_xfer;

    assign in_xfer  = push && !full;
    assign out_xfer = pop && !empty;

    always_comb
    begin
        held_next = held_reg;
        if (in_xfer && !out_xfer)
        begin
            held_next = held_reg + HELD_W'(1);
        end
        else if (out_xfer && !in_xfer)
        begin
            held_next = held_reg - HELD_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg <= '0;
        end
        else
        begin
            held_reg <= held_next;
        end
    end

    a_held_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        held_reg <= HELD_W'(CAP))
        else $error("more items in flight than the block can hold");

    a_result_has_item: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> held_reg != '0)
        else $error("result shown with no item in flight");

    a_full_has_item: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> held_reg != '0)
        else $error("full raised with no item in flight");

    a_result_stays: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !pop |=> !empty)
        else $error("waiting result withdrawn");

    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !pop |=> $stable(pos_x) && $stable(pos_y) && $stable(elapsed_time)
                           && $stable(stepped) && $stable(finished))
        else $error("waiting result changed before its transfer");

endmodule

bind quenched_trap_walk_step qtw_checker u_qtw_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .push         (push),
    .full         (full),
    .pop          (pop),
    .empty        (empty),
    .pos_x        (pos_x),
    .pos_y        (pos_y),
    .elapsed_time (elapsed_time),
    .stepped      (stepped),
    .finished     (finished)
);
